// File: hw/rtl/chol_pkg.sv
package chol_pkg;

    // Sizes
    localparam int N_MAX     = 8;
    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;                      // element width
    localparam int MEM_D     = N_MAX * N_MAX;           // element store depth
    localparam int AW        = $clog2(MEM_D);           // store address width
    localparam int CW        = AW + 1;                  // element count width
    localparam int IW        = $clog2(N_MAX);           // row / column index width
    localparam int NW        = 4;                       // matrix_size width
    localparam int ACC_W     = 2 * DW + 4;              // dot product accumulator
    localparam int RT_W      = 2 * (DW - 1);            // root operand width
    localparam int SQ_CW     = $clog2(DW);              // root step counter width
    localparam int DV_CW     = $clog2(ACC_W + 1);       // divide step counter width

    localparam logic [NW-1:0] SIZE_RESET = NW'(N_MAX);
    localparam logic [DW-1:0] SAT_POS    = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SAT_NEG    = {1'b1, {(DW-1){1'b0}}};

    // Store write source
    typedef enum logic [1:0] {
        WS_IN,
        WS_ROOT,
        WS_QUOT,
        WS_ZERO
    } t_wsrc;

    // Controller to datapath
    typedef struct packed {
        logic            we;
        logic [AW-1:0]   waddr;
        t_wsrc           wsrc;
        logic [AW-1:0]   raddr;
        logic            ld_a;
        logic            ld_x;
        logic            mul;
        logic            acc_sub;
        logic            root_start;
        logic            div_start;
        logic            out_load;
        logic            clr_flags;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic root_busy;
        logic div_busy;
    } t_status;

endpackage

// File: hw/rtl/chol_if.sv
// Configuration write channel
interface chol_cfg_if import chol_pkg::*;;
    logic          valid;
    logic          ready;
    logic [NW-1:0] matrix_size;
    modport source(output valid, matrix_size, input ready);
    modport sink(input valid, matrix_size, output ready);
endinterface

// Matrix element input channel
interface chol_in_if import chol_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] a_value;
    modport source(output valid, a_value, input ready);
    modport sink(input valid, a_value, output ready);
endinterface

// Factor element output channel
interface chol_out_if import chol_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] l_value;
    logic                 last;
    logic                 pivot_error;
    logic                 overflow;
    modport source(output valid, l_value, last, pivot_error, overflow, input ready);
    modport sink(input valid, l_value, last, pivot_error, overflow, output ready);
endinterface

// File: hw/rtl/cholesky_decomposer.sv
// Channel  Dir  Signals                                           Transaction
// i_cfg    in   valid, ready, matrix_size[3:0]                    valid & ready
// i_a      in   valid, ready, a_value[31:0]                       valid & ready
// o_l      out  valid, ready, l_value[31:0], last, pivot_error,   valid & ready
//               overflow
//
// One element is loaded per cycle while loading; the n*n-th starts the
// factorization. Per (i,k) entry each dot product term reads two operands
// through the single store read port, multiplies and subtracts; a diagonal
// entry then takes a root and an off-diagonal one a divide (one quotient bit
// per cycle). Results leave one at a time, each held until taken.
// i_cfg is always ready and clears the partial matrix and the flags.
// Reset is synchronous; the output stalls freely, holding the result.
module cholesky_decomposer import chol_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chol_cfg_if.sink    i_cfg,
    chol_in_if.sink     i_a,
    chol_out_if.source  o_l
);

    t_cmd    w_cmd;
    t_status w_status;
    logic [DW-1:0] w_l;

    chol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.matrix_size),
        .o_cfg_ready (i_cfg.ready),
        .i_in_valid  (i_a.valid),
        .o_in_ready  (i_a.ready),
        .o_out_valid (o_l.valid),
        .o_out_last  (o_l.last),
        .i_out_ready (o_l.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    chol_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_in_data     (i_a.a_value),
        .o_status      (w_status),
        .o_l_value     (w_l),
        .o_pivot_error (o_l.pivot_error),
        .o_overflow    (o_l.overflow)
    );

    assign o_l.l_value = signed'(w_l);

endmodule

// File: hw/rtl/chol_dp.sv
module chol_dp import chol_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [DW-1:0] i_in_data,
    output t_status       o_status,
    output logic [DW-1:0] o_l_value,
    output logic          o_pivot_error,
    output logic          o_overflow
);

    // Element store
    logic [DW-1:0] r_mem [MEM_D];
    logic [DW-1:0] r_rdata;
    logic [DW-1:0] w_wdata;

    // MAC
    logic [DW-1:0]               r_x;
    logic signed [2*DW-1:0]      r_prod;
    logic [ACC_W-1:0]            r_acc;
    logic signed [DW-1:0]        w_xs;
    logic signed [DW-1:0]        w_ys;

    // Root unit
    logic             r_sq_busy;
    logic [SQ_CW-1:0] r_sq_cnt;
    logic [RT_W-1:0]  r_sq_v;
    logic [DW:0]      r_sq_rem;
    logic [DW-2:0]    r_sq_root;
    logic [DW-1:0]    r_root_res;
    logic [DW+1:0]    w_sq_sh;
    logic [DW+1:0]    w_sq_trial;
    logic             w_sq_ge;
    logic [DW+1:0]    w_sq_diff;
    logic [DW-2:0]    w_sq_root_n;

    // Divide unit
    logic             r_dv_busy;
    logic [DV_CW-1:0] r_dv_cnt;
    logic [ACC_W-1:0] r_dv_q;
    logic [DW-1:0]    r_dv_rem;
    logic [DW-1:0]    r_dv_d;
    logic             r_dv_neg;
    logic [DW-1:0]    r_quot;
    logic [DW:0]      w_dv_sh;
    logic             w_dv_ge;
    logic [DW:0]      w_dv_diff;
    logic [ACC_W-1:0] w_dv_qn;

    // Output and flags
    logic [DW-1:0] r_l;
    logic          r_pivot;
    logic          r_ovf;

    // Write data select
    always_comb begin
        case (i_cmd.wsrc)
            WS_IN:   w_wdata = i_in_data;
            WS_ROOT: w_wdata = r_root_res;
            WS_QUOT: w_wdata = r_quot;
            default: w_wdata = '0;
        endcase
    end

    // Store with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= w_wdata;
        end
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign w_xs = signed'(r_x);
    assign w_ys = signed'(r_rdata);

    // Root step: two operand bits per cycle
    assign w_sq_sh     = {r_sq_rem[DW-1:0], r_sq_v[RT_W-1 -: 2]};
    assign w_sq_trial  = {1'b0, r_sq_root, 2'b01};
    assign w_sq_ge     = w_sq_sh >= w_sq_trial;
    assign w_sq_diff   = w_sq_sh - w_sq_trial;
    assign w_sq_root_n = {r_sq_root[DW-3:0], w_sq_ge};

    // Divide step: one quotient bit per cycle
    assign w_dv_sh   = {r_dv_rem, r_dv_q[ACC_W-1]};
    assign w_dv_ge   = w_dv_sh >= {1'b0, r_dv_d};
    assign w_dv_diff = w_dv_sh - {1'b0, r_dv_d};
    assign w_dv_qn   = {r_dv_q[ACC_W-2:0], w_dv_ge};

    // Arithmetic units and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_dv_busy <= 1'b0;
            r_pivot   <= 1'b0;
            r_ovf     <= 1'b0;
        end else begin
            if (i_cmd.ld_a) begin
                r_acc <= {{(ACC_W-DW){r_rdata[DW-1]}}, r_rdata} << FRAC_BITS;
            end
            if (i_cmd.ld_x) begin
                r_x <= r_rdata;
            end
            if (i_cmd.mul) begin
                r_prod <= w_xs * w_ys;
            end
            if (i_cmd.acc_sub) begin
                r_acc <= r_acc - {{(ACC_W-2*DW){r_prod[2*DW-1]}}, r_prod};
            end
            if (i_cmd.out_load) begin
                r_l <= r_rdata;
            end

            // root: negative clamps to zero, too large saturates
            if (i_cmd.root_start) begin
                if (r_acc[ACC_W-1]) begin
                    r_root_res <= '0;
                    r_pivot    <= 1'b1;
                end else if (|r_acc[ACC_W-1:RT_W]) begin
                    r_root_res <= SAT_POS;
                    r_ovf      <= 1'b1;
                end else begin
                    r_sq_v    <= r_acc[RT_W-1:0];
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_sq_cnt  <= SQ_CW'(DW - 1);
                    r_sq_busy <= 1'b1;
                end
            end else if (r_sq_busy) begin
                r_sq_v    <= r_sq_v << 2;
                r_sq_rem  <= w_sq_ge ? w_sq_diff[DW:0] : w_sq_sh[DW:0];
                r_sq_root <= w_sq_root_n;
                r_sq_cnt  <= r_sq_cnt - 1'b1;
                if (r_sq_cnt == SQ_CW'(1)) begin
                    r_sq_busy  <= 1'b0;
                    r_root_res <= {1'b0, w_sq_root_n};
                    if (w_sq_root_n == '0) begin
                        r_pivot <= 1'b1;
                    end
                end
            end

            // divide magnitude, then sign and saturate
            if (i_cmd.div_start) begin
                r_dv_neg <= r_acc[ACC_W-1];
                if (r_rdata == '0) begin
                    r_quot  <= r_acc[ACC_W-1] ? SAT_NEG : SAT_POS;
                    r_pivot <= 1'b1;
                end else begin
                    r_dv_q    <= r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
                    r_dv_d    <= r_rdata;
                    r_dv_rem  <= '0;
                    r_dv_cnt  <= DV_CW'(ACC_W);
                    r_dv_busy <= 1'b1;
                end
            end else if (r_dv_busy) begin
                r_dv_q   <= w_dv_qn;
                r_dv_rem <= w_dv_ge ? w_dv_diff[DW-1:0] : w_dv_sh[DW-1:0];
                r_dv_cnt <= r_dv_cnt - 1'b1;
                if (r_dv_cnt == DV_CW'(1)) begin
                    r_dv_busy <= 1'b0;
                    if (!r_dv_neg) begin
                        if (w_dv_qn > ACC_W'(SAT_POS)) begin
                            r_quot <= SAT_POS;
                            r_ovf  <= 1'b1;
                        end else begin
                            r_quot <= w_dv_qn[DW-1:0];
                        end
                    end else begin
                        if (w_dv_qn > ACC_W'(SAT_NEG)) begin
                            r_quot <= SAT_NEG;
                            r_ovf  <= 1'b1;
                        end else begin
                            r_quot <= ~w_dv_qn[DW-1:0] + 1'b1;
                        end
                    end
                end
            end

            if (i_cmd.clr_flags) begin
                r_pivot <= 1'b0;
                r_ovf   <= 1'b0;
            end
        end
    end

    assign o_status.root_busy = r_sq_busy;
    assign o_status.div_busy  = r_dv_busy;
    assign o_l_value          = r_l;
    assign o_pivot_error      = r_pivot;
    assign o_overflow         = r_ovf;

endmodule

// File: hw/rtl/chol_ctrl.sv
module chol_ctrl import chol_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [NW-1:0] i_cfg_data,
    output logic          o_cfg_ready,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output logic          o_out_last,
    input  logic          i_out_ready,
    input  t_status       i_status,
    output t_cmd          o_cmd
);

    typedef enum logic [3:0] {
        S_LOAD, S_A, S_A2, S_RX, S_RY, S_MUL, S_ACC, S_FIN,
        S_PIV, S_ROOT, S_DIV, S_ZERO, S_OUT, S_OUTW, S_OUTH
    } t_state;

    t_state        r_state;
    logic [NW-1:0] r_size;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_j;
    logic [AW-1:0] r_e;
    logic          r_out_valid;
    logic          r_last;

    logic [NW-1:0] w_n;
    logic [IW-1:0] w_nm1;
    logic [CW-1:0] w_total;
    logic          w_in_acc;
    logic          w_cfg_acc;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] a, input logic [IW-1:0] b,
                                             input logic [NW-1:0] n);
        logic [2*NW-1:0] t;
        t = (2*NW)'(a) * (2*NW)'(n) + (2*NW)'(b);
        return t[AW-1:0];
    endfunction

    // Order in use, clamped to 1..N_MAX
    always_comb begin
        if (r_size == '0) begin
            w_n = NW'(1);
        end else if (r_size > NW'(N_MAX)) begin
            w_n = NW'(N_MAX);
        end else begin
            w_n = r_size;
        end
    end

    assign w_nm1     = IW'(w_n - 1'b1);
    assign w_total   = CW'(w_n * w_n);
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc = i_cfg_valid;
    assign o_in_ready  = (r_state == S_LOAD);
    assign w_in_acc  = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_last;

    // Datapath commands
    always_comb begin
        o_cmd       = '0;
        o_cmd.wsrc  = WS_IN;
        case (r_state)
            S_LOAD: begin
                o_cmd.we    = w_in_acc;
                o_cmd.waddr = r_count[AW-1:0];
            end
            S_A:    o_cmd.raddr = f_addr(r_i, r_k, w_n);
            S_A2:   o_cmd.ld_a = 1'b1;
            S_RX:   o_cmd.raddr = f_addr(r_i, r_j, w_n);
            S_RY: begin
                o_cmd.raddr = f_addr(r_k, r_j, w_n);
                o_cmd.ld_x  = 1'b1;
            end
            S_MUL:  o_cmd.mul = 1'b1;
            S_ACC:  o_cmd.acc_sub = 1'b1;
            S_FIN: begin
                if (r_i == r_k) begin
                    o_cmd.root_start = 1'b1;
                end else begin
                    o_cmd.raddr = f_addr(r_k, r_k, w_n);
                end
            end
            S_PIV:  o_cmd.div_start = 1'b1;
            S_ROOT: begin
                o_cmd.we    = !i_status.root_busy;
                o_cmd.waddr = f_addr(r_i, r_k, w_n);
                o_cmd.wsrc  = WS_ROOT;
            end
            S_DIV: begin
                o_cmd.we    = !i_status.div_busy;
                o_cmd.waddr = f_addr(r_i, r_k, w_n);
                o_cmd.wsrc  = WS_QUOT;
            end
            S_ZERO: begin
                o_cmd.we    = 1'b1;
                o_cmd.waddr = f_addr(r_i, r_k, w_n);
                o_cmd.wsrc  = WS_ZERO;
            end
            S_OUT:  o_cmd.raddr = r_e;
            S_OUTW: o_cmd.out_load = 1'b1;
            S_OUTH: o_cmd.clr_flags = i_out_ready && r_last;
            default: ;
        endcase
        if (w_cfg_acc) begin
            o_cmd.clr_flags = 1'b1;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_size      <= SIZE_RESET;
            r_count     <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_e         <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (w_in_acc) begin
                        if (r_count + 1'b1 == w_total) begin
                            r_count <= '0;
                            r_i     <= '0;
                            r_k     <= '0;
                            r_state <= S_A;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_A: r_state <= S_A2;
                S_A2: begin
                    r_j     <= '0;
                    r_state <= (r_k == '0) ? S_FIN : S_RX;
                end
                S_RX:  r_state <= S_RY;
                S_RY:  r_state <= S_MUL;
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    if ({1'b0, r_j} + 1'b1 == {1'b0, r_k}) begin
                        r_state <= S_FIN;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RX;
                    end
                end
                S_FIN: r_state <= (r_i == r_k) ? S_ROOT : S_PIV;
                S_PIV: r_state <= S_DIV;
                S_ROOT: begin
                    if (!i_status.root_busy) begin
                        if (r_i == w_nm1) begin
                            r_e     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_k     <= r_i + 1'b1;
                            r_state <= S_ZERO;
                        end
                    end
                end
                S_DIV: begin
                    if (!i_status.div_busy) begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_A;
                    end
                end
                S_ZERO: begin
                    if (r_k == w_nm1) begin
                        r_i     <= r_i + 1'b1;
                        r_k     <= '0;
                        r_state <= S_A;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_OUT: r_state <= S_OUTW;
                S_OUTW: begin
                    r_out_valid <= 1'b1;
                    r_last      <= ({1'b0, r_e} + 1'b1 == w_total);
                    r_state     <= S_OUTH;
                end
                S_OUTH: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_e     <= r_e + 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase

            // register write drops the partial matrix
            if (w_cfg_acc) begin
                r_size      <= i_cfg_data;
                r_count     <= '0;
                r_state     <= S_LOAD;
                r_out_valid <= 1'b0;
            end
        end
    end

    // Checks
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("output valid while loading");

    a_count_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_count < w_total))
        else $error("element count past matrix end");

    a_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.we && o_cmd.wsrc == WS_IN) |-> w_in_acc)
        else $error("input write without transaction");

    a_root_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.root_start && !w_cfg_acc) |=> (r_state == S_ROOT))
        else $error("root started outside sequence");

endmodule
